[hdl/path_coordinate_parser_macros.svh]
// Assertion macros used by the path coordinate parser RTL.
// Depends on nothing; included by pcp_fifo, the file that carries concurrent checks.
`ifndef PATH_COORDINATE_PARSER_MACROS_SVH
`define PATH_COORDINATE_PARSER_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define PCP_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("pcp assertion failed");

// Check that a condition implies another in the next cycle.
`define PCP_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("pcp assertion failed");

`endif

[hdl/pcp_pkg.sv]
// Package for the path coordinate parser: defaults, character codes, types.
// Depends on nothing; imported by the RTL modules, pcp_if and the testbench files.
`default_nettype none

package pcp_pkg;

   localparam int DEFAULT_MAX_POINTS  = 64;
   localparam int DEFAULT_COORD_WIDTH = 16;
   localparam int FIFO_DEPTH          = 4;

   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_MOVE   = 8'h4D;
   localparam logic [7:0] CHAR_LINE   = 8'h4C;
   localparam logic [7:0] CHAR_CURVE  = 8'h43;
   localparam logic [7:0] CHAR_CLOSE  = 8'h7A;

   localparam logic [2:0] LINE_NUMBERS  = 3'd2;
   localparam logic [2:0] CURVE_NUMBERS = 3'd6;

   typedef enum logic [1:0] {
      MODE_SEEK    = 2'd0,
      MODE_COLLECT = 2'd1,
      MODE_DONE    = 2'd2
   } parse_mode_type;

   typedef struct packed {
      logic first_valid;
      logic second_valid;
   } pcp_push_type;

endpackage

`default_nettype wire

[hdl/pcp_if.sv]
// Channel interfaces of the path coordinate parser: character in, result out.
// Depends on pcp_pkg for default widths.
`default_nettype none

interface pcp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_string;

   modport source (output valid, output char_code, output end_of_string, input ready);
   modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface pcp_rsp_if
   import pcp_pkg::*;
#(
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH,
   parameter int IDX_WIDTH   = 6,
   parameter int CNT_WIDTH   = 7
);
   logic                   valid;
   logic                   ready;
   logic                   is_summary;
   logic [COORD_WIDTH-1:0] x_coord;
   logic [COORD_WIDTH-1:0] y_coord;
   logic [IDX_WIDTH-1:0]   point_index;
   logic [CNT_WIDTH-1:0]   point_count;
   logic                   has_arc;
   logic                   last_of_run;

   modport source (output valid, output is_summary, output x_coord, output y_coord,
                   output point_index, output point_count, output has_arc,
                   output last_of_run, input ready);
   modport sink   (input valid, input is_summary, input x_coord, input y_coord,
                   input point_index, input point_count, input has_arc,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

[hdl/path_coordinate_parser.sv]
// Top level of the path coordinate parser: core and result queue.
// Depends on pcp_pkg, pcp_if, pcp_core and pcp_fifo.
//
// Takes one path character per clock on req_bus, while the result queue has
// room, and returns point results and one end-of-path summary on rsp_bus.
// A character passes the input register and then enters the result queue,
// from whose head its first result is presented on rsp_bus. Characters are
// accepted every cycle as long as the four-entry result queue has room for two
// results; the final character of a string that also completes a point
// yields two results, which leave one after the other through the single
// result port, so sustained rate is one character per cycle with one extra
// output result per such string end.
`default_nettype none

module path_coordinate_parser
   import pcp_pkg::*;
#(
   parameter int MAX_POINTS  = DEFAULT_MAX_POINTS,
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH
) (
   input  wire logic clock,
   input  wire logic reset,
   pcp_req_if.sink   req_bus,
   pcp_rsp_if.source rsp_bus
);

   localparam int IDX_WIDTH = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_WIDTH = $clog2(MAX_POINTS + 1);
   localparam int RSP_WIDTH = 2 * COORD_WIDTH + IDX_WIDTH + CNT_WIDTH + 3;

   pcp_push_type         push;
   logic                 room;
   logic [RSP_WIDTH-1:0] first_data;
   logic [RSP_WIDTH-1:0] second_data;
   logic [RSP_WIDTH-1:0] out_data;

   pcp_core #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH),
      .IDX_WIDTH   (IDX_WIDTH),
      .CNT_WIDTH   (CNT_WIDTH),
      .RSP_WIDTH   (RSP_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_bus.valid),
      .in_ready    (req_bus.ready),
      .in_char     (req_bus.char_code),
      .in_eos      (req_bus.end_of_string),
      .room        (room),
      .push        (push),
      .first_data  (first_data),
      .second_data (second_data)
   );

   pcp_fifo #(
      .WIDTH (RSP_WIDTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .first_data  (first_data),
      .second_data (second_data),
      .room        (room),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_data    (out_data)
   );

   assign {rsp_bus.is_summary, rsp_bus.x_coord, rsp_bus.y_coord, rsp_bus.point_index,
           rsp_bus.point_count, rsp_bus.has_arc, rsp_bus.last_of_run} = out_data;

endmodule

`default_nettype wire

[hdl/pcp_core.sv]
// Parser core: input register, parse state machine and result formatting.
// Depends on pcp_pkg; feeds up to two packed results per character to pcp_fifo.
`default_nettype none

module pcp_core
   import pcp_pkg::*;
#(
   parameter int MAX_POINTS  = DEFAULT_MAX_POINTS,
   parameter int COORD_WIDTH = DEFAULT_COORD_WIDTH,
   parameter int IDX_WIDTH   = 6,
   parameter int CNT_WIDTH   = 7,
   parameter int RSP_WIDTH   = 2 * COORD_WIDTH + IDX_WIDTH + CNT_WIDTH + 3
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic [7:0]           in_char,
   input  wire logic                 in_eos,
   input  wire logic                 room,
   output pcp_push_type              push,
   output logic [RSP_WIDTH-1:0]      first_data,
   output logic [RSP_WIDTH-1:0]      second_data
);

   localparam logic [COORD_WIDTH-1:0] COORD_MAX = {COORD_WIDTH{1'b1}};
   localparam logic [CNT_WIDTH-1:0]   POINT_LIMIT = CNT_WIDTH'(MAX_POINTS);

   logic                   valid_ff;
   logic [7:0]             char_ff;
   logic                   eos_ff;
   logic                   fire;

   parse_mode_type         mode_ff,   mode_in;
   logic [2:0]             left_ff,   left_in;
   logic                   innum_ff,  innum_in;
   logic [COORD_WIDTH-1:0] acc_ff,    acc_in;
   logic [COORD_WIDTH-1:0] px_ff,     px_in;
   logic [CNT_WIDTH-1:0]   taken_ff,  taken_in;
   logic                   arc_ff,    arc_in;

   logic                   is_digit;
   logic                   do_seek;
   logic                   pt_valid;
   logic [COORD_WIDTH+3:0] base;
   logic [COORD_WIDTH+3:0] prod;
   logic [RSP_WIDTH-1:0]   point_word;
   logic [RSP_WIDTH-1:0]   summary_word;
   logic [CNT_WIDTH-1:0]   taken_next;
   logic                   arc_next;

   assign fire     = valid_ff && room;
   assign in_ready = !valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (fire) begin
         valid_ff <= 1'b0;
      end
      if (in_valid && in_ready) begin
         char_ff <= in_char;
         eos_ff  <= in_eos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SEEK;
         left_ff  <= 3'd0;
         innum_ff <= 1'b0;
         acc_ff   <= '0;
         px_ff    <= '0;
         taken_ff <= '0;
         arc_ff   <= 1'b0;
      end else if (fire) begin
         mode_ff  <= mode_in;
         left_ff  <= left_in;
         innum_ff <= innum_in;
         acc_ff   <= acc_in;
         px_ff    <= px_in;
         taken_ff <= taken_in;
         arc_ff   <= arc_in;
      end
   end

   assign is_digit = (char_ff >= CHAR_ZERO) && (char_ff <= CHAR_NINE);
   assign base     = innum_ff ? {4'b0000, acc_ff} : '0;
   assign prod     = (base << 3) + (base << 1) + {{COORD_WIDTH{1'b0}}, 4'(char_ff - CHAR_ZERO)};

   always_comb begin
      mode_in  = mode_ff;
      left_in  = left_ff;
      innum_in = innum_ff;
      acc_in   = acc_ff;
      px_in    = px_ff;
      taken_in = taken_ff;
      arc_in   = arc_ff;
      do_seek  = 1'b0;
      pt_valid = 1'b0;

      unique case (mode_ff)
         MODE_SEEK: begin
            do_seek = 1'b1;
         end
         MODE_COLLECT: begin
            if (is_digit) begin
               innum_in = 1'b1;
               acc_in   = (prod > {4'b0000, COORD_MAX}) ? COORD_MAX : prod[COORD_WIDTH-1:0];
            end else if (innum_ff) begin
               innum_in = 1'b0;
               if (!left_ff[0]) begin
                  px_in = acc_ff;
               end else begin
                  pt_valid = 1'b1;
                  taken_in = taken_ff + 1'b1;
               end
               left_in = left_ff - 3'd1;
               if (taken_in >= POINT_LIMIT) begin
                  mode_in = MODE_DONE;
                  left_in = 3'd0;
               end else if (left_in == 3'd0) begin
                  do_seek = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      if (do_seek) begin
         mode_in = MODE_SEEK;
         priority if (char_ff == CHAR_MOVE || char_ff == CHAR_LINE) begin
            mode_in  = MODE_COLLECT;
            left_in  = LINE_NUMBERS;
            innum_in = 1'b0;
         end else if (char_ff == CHAR_CURVE) begin
            mode_in  = MODE_COLLECT;
            left_in  = CURVE_NUMBERS;
            innum_in = 1'b0;
            arc_in   = 1'b1;
         end else if (char_ff == CHAR_CLOSE) begin
            mode_in  = MODE_DONE;
         end else begin
         end
      end

      taken_next = taken_in;
      arc_next   = arc_in;

      if (eos_ff) begin
         mode_in  = MODE_SEEK;
         left_in  = 3'd0;
         innum_in = 1'b0;
         acc_in   = '0;
         px_in    = '0;
         taken_in = '0;
         arc_in   = 1'b0;
      end
   end

   assign point_word   = {1'b0, px_ff, acc_ff, taken_ff[IDX_WIDTH-1:0],
                          {CNT_WIDTH{1'b0}}, 1'b0, !eos_ff};
   assign summary_word = {1'b1, {COORD_WIDTH{1'b0}}, {COORD_WIDTH{1'b0}},
                          {IDX_WIDTH{1'b0}}, taken_next, arc_next, 1'b1};

   assign push        = pcp_push_type'{first_valid:  fire && (pt_valid || eos_ff),
                                       second_valid: fire && pt_valid && eos_ff};
   assign first_data  = pt_valid ? point_word : summary_word;
   assign second_data = summary_word;

endmodule

`default_nettype wire

[hdl/pcp_fifo.sv]
// Four-entry result queue taking up to two results a cycle, one out a cycle while out_ready is high.
// Depends on pcp_pkg and the assertion macros header.
`default_nettype none

`include "path_coordinate_parser_macros.svh"

module pcp_fifo
   import pcp_pkg::*;
#(
   parameter int WIDTH = 48
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pcp_push_type     push,
   input  wire logic [WIDTH-1:0] first_data,
   input  wire logic [WIDTH-1:0] second_data,
   output logic                  room,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   localparam int PTR_WIDTH = $clog2(FIFO_DEPTH);
   localparam int CNT_WIDTH = $clog2(FIFO_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_COUNT = CNT_WIDTH'(FIFO_DEPTH);
   localparam logic [CNT_WIDTH-1:0] ROOM_LIMIT  = CNT_WIDTH'(FIFO_DEPTH - 2);

   logic [WIDTH-1:0]     mem_ff [FIFO_DEPTH];
   logic [PTR_WIDTH-1:0] head_ff, head_in;
   logic [PTR_WIDTH-1:0] tail_ff, tail_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 pop;
   logic [1:0]           pushes;

   assign pop       = out_valid && out_ready;
   assign pushes    = {1'b0, push.first_valid} + {1'b0, push.second_valid};
   assign room      = count_ff <= ROOM_LIMIT;
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[head_ff];

   assign head_in  = head_ff + PTR_WIDTH'(pop);
   assign tail_in  = tail_ff + PTR_WIDTH'(pushes);
   assign count_in = count_ff + CNT_WIDTH'(pushes) - CNT_WIDTH'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[tail_ff] <= first_data;
      end
      if (push.second_valid) begin
         mem_ff[tail_ff + PTR_WIDTH'(1)] <= second_data;
      end
   end

   `PCP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= DEPTH_COUNT)
   `PCP_ASSERT_IMPLY(a_push_order, clock, reset, push.second_valid, push.first_valid)
   `PCP_ASSERT_IMPLY(a_push_room, clock, reset, push.first_valid, count_ff <= ROOM_LIMIT)
   `PCP_ASSERT_NEXT(a_count_track, clock, reset, pushes == 2'd0 && !pop, $stable(count_ff))

endmodule

`default_nettype wire

[tb/sv/path_result_checker.sv]
`timescale 1ns / 1ps
// Checker for the path coordinate parser: watches the character and result channels,
// predicts point and summary results per accepted character, and compares them in order.
// Depends on pcp_pkg and the channel interfaces in pcp_if.

module path_result_checker
   import pcp_pkg::*;
#(
   parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
   input  wire logic clock,
   input  wire logic reset,
   pcp_req_if        req_mon,
   pcp_rsp_if        rsp_mon,
   output int        mismatch_count,
   output int        pending_results
);

   localparam logic [15:0] COORD_LIMIT = 16'hFFFF;

   typedef struct packed {
      logic        is_summary;
      logic [15:0] x_coord;
      logic [15:0] y_coord;
      logic [5:0]  point_index;
      logic [6:0]  point_count;
      logic        has_arc;
      logic        last_of_run;
   } path_result_type;

   parse_mode_type  mode;
   logic [2:0]      numbers_left;
   logic            in_number;
   logic [15:0]     accumulator;
   logic [15:0]     pending_x;
   logic [6:0]      points_taken;
   logic            arc_seen;
   path_result_type expected_results[$];

   function automatic void clear_parser();
      mode         = MODE_SEEK;
      numbers_left = '0;
      in_number    = 1'b0;
      accumulator  = '0;
      pending_x    = '0;
      points_taken = '0;
      arc_seen     = 1'b0;
   endfunction

   function automatic void start_command(input logic [7:0] ch);
      if (ch == CHAR_MOVE || ch == CHAR_LINE) begin
         mode         = MODE_COLLECT;
         numbers_left = LINE_NUMBERS;
         in_number    = 1'b0;
      end else if (ch == CHAR_CURVE) begin
         mode         = MODE_COLLECT;
         numbers_left = CURVE_NUMBERS;
         in_number    = 1'b0;
         arc_seen     = 1'b1;
      end else if (ch == CHAR_CLOSE) begin
         mode = MODE_DONE;
      end
   endfunction

   function automatic void parse_character(input logic [7:0] ch, input logic eos);
      int              produced;
      logic [19:0]     scaled;
      path_result_type entry;
      produced = 0;
      case (mode)
         MODE_SEEK: begin
            start_command(ch);
         end
         MODE_COLLECT: begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
               if (!in_number) begin
                  accumulator = '0;
                  in_number   = 1'b1;
               end
               scaled = accumulator * 20'd10 + 20'(ch - CHAR_ZERO);
               accumulator = (scaled > 20'(COORD_LIMIT)) ? COORD_LIMIT : scaled[15:0];
            end else if (in_number) begin
               in_number = 1'b0;
               if (!numbers_left[0]) begin
                  pending_x = accumulator;
               end else begin
                  entry             = '0;
                  entry.x_coord     = pending_x;
                  entry.y_coord     = accumulator;
                  entry.point_index = points_taken[5:0];
                  expected_results.push_back(entry);
                  produced++;
                  points_taken++;
               end
               numbers_left = numbers_left - 3'd1;
               if (int'(points_taken) >= MAX_POINTS) begin
                  mode         = MODE_DONE;
                  numbers_left = '0;
               end else if (numbers_left == 3'd0) begin
                  mode = MODE_SEEK;
                  start_command(ch);
               end
            end
         end
         default: begin
         end
      endcase
      if (eos) begin
         entry             = '0;
         entry.is_summary  = 1'b1;
         entry.point_count = points_taken;
         entry.has_arc     = arc_seen;
         expected_results.push_back(entry);
         produced++;
         clear_parser();
      end
      if (produced > 0)
         expected_results[expected_results.size() - 1].last_of_run = 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("%0t ns: mismatch in %s: expected %0d, got %0d", $time, what, want, got);
      mismatch_count++;
   endtask

   task automatic compare_result(input path_result_type got);
      path_result_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result transaction with nothing pending", 0, 1);
         return;
      end
      want = expected_results.pop_front();
      if (got.is_summary !== want.is_summary)
         report_mismatch("is_summary", want.is_summary, got.is_summary);
      if (got.x_coord !== want.x_coord)
         report_mismatch("x_coord", want.x_coord, got.x_coord);
      if (got.y_coord !== want.y_coord)
         report_mismatch("y_coord", want.y_coord, got.y_coord);
      if (got.point_index !== want.point_index)
         report_mismatch("point_index", want.point_index, got.point_index);
      if (got.point_count !== want.point_count)
         report_mismatch("point_count", want.point_count, got.point_count);
      if (got.has_arc !== want.has_arc)
         report_mismatch("has_arc", want.has_arc, got.has_arc);
      if (got.last_of_run !== want.last_of_run)
         report_mismatch("last_of_run", want.last_of_run, got.last_of_run);
   endtask

   always @(posedge clock) begin
      path_result_type seen;
      if (reset) begin
         clear_parser();
         expected_results.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.is_summary  = rsp_mon.is_summary;
            seen.x_coord     = rsp_mon.x_coord;
            seen.y_coord     = rsp_mon.y_coord;
            seen.point_index = rsp_mon.point_index;
            seen.point_count = rsp_mon.point_count;
            seen.has_arc     = rsp_mon.has_arc;
            seen.last_of_run = rsp_mon.last_of_run;
            compare_result(seen);
         end
         if (req_mon.valid && req_mon.ready)
            parse_character(req_mon.char_code, req_mon.end_of_string);
      end
      pending_results = expected_results.size();
   end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// Top of the path coordinate parser testbench: clock, reset, path character stimulus,
// result back-pressure and the verdict. Depends on pcp_pkg, pcp_if, the parser RTL
// and path_result_checker.

module testbench;
   import pcp_pkg::*;

   localparam int          CLOCK_PERIOD  = 20;
   localparam int          RESET_CYCLES  = 9;
   localparam int          RANDOM_ITEMS  = 1380;
   localparam int          LONG_POINTS   = 70;
   localparam int          TAIL_CYCLES   = 10;
   localparam int          CYCLE_LIMIT   = 400000;
   localparam logic [7:0]  CHAR_SPACE    = 8'h20;
   localparam logic [7:0]  CHAR_COMMA    = 8'h2C;
   localparam logic [7:0]  CHAR_MINUS    = 8'h2D;
   localparam logic [7:0]  CHAR_NEWLINE  = 8'h0A;
   localparam logic [7:0]  CHAR_LOW      = 8'h00;
   localparam logic [7:0]  CHAR_HIGH     = 8'hFF;

   typedef struct packed {
      logic [7:0] ch;
      logic       eos;
   } path_char_type;

   typedef enum int {FLOW_OPEN, FLOW_PATTERN, FLOW_SPARSE} flow_style_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   int             mismatch_count;
   int             pending_results;
   int             cycle_count = 0;
   path_char_type  stimulus[$];
   flow_style_type stall_style = FLOW_OPEN;
   int             stall_span = 0;
   logic [15:0]    stall_pattern = 16'hFFFF;

   pcp_req_if req_bus ();
   pcp_rsp_if rsp_bus ();

   path_coordinate_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   path_result_checker checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_bus),
      .rsp_mon         (rsp_bus),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (stall_span == 0) begin
         stall_style   = flow_style_type'($urandom_range(0, 2));
         stall_span    = $urandom_range(16, 160);
         stall_pattern = 16'($urandom);
      end
      stall_span--;
      stall_pattern = {stall_pattern[14:0], stall_pattern[15]};
      case (stall_style)
         FLOW_OPEN:    rsp_bus.ready <= 1'b1;
         FLOW_PATTERN: rsp_bus.ready <= stall_pattern[0];
         default:      rsp_bus.ready <= (stall_pattern[1:0] == 2'b00);
      endcase
   end

   function automatic void push_char(input logic [7:0] ch);
      path_char_type item;
      item.ch  = ch;
      item.eos = 1'b0;
      stimulus.push_back(item);
   endfunction

   function automatic void push_text(input string s);
      foreach (s[i])
         push_char(s[i]);
   endfunction

   function automatic void end_path();
      stimulus[stimulus.size() - 1].eos = 1'b1;
   endfunction

   function automatic logic [7:0] random_separator();
      logic [7:0] ch;
      case ($urandom_range(0, 5))
         0, 1:    ch = CHAR_SPACE;
         2:       ch = CHAR_COMMA;
         3:       ch = CHAR_MINUS;
         4:       ch = CHAR_NEWLINE;
         default: begin
            do
               ch = 8'($urandom_range(0, 255));
            while (ch >= CHAR_ZERO && ch <= CHAR_NINE);
         end
      endcase
      return ch;
   endfunction

   function automatic longint random_value(input bit compact);
      if (compact)
         return $urandom_range(0, 99);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom_range(0, 65535);
         4, 5:       return $urandom_range(0, 9);
         6:          return $urandom_range(65530, 65540);
         7:          return $urandom_range(100000, 9999999);
         8:          return $urandom_range(0, 999999999);
         default:    return $urandom_range(0, 999);
      endcase
   endfunction

   function automatic void append_random_path(input int point_goal);
      logic [7:0] text[$];
      string      digits;
      int         points;
      int         commands;
      int         numbers;
      int         kind;
      int         cut;
      points = 0;
      if (point_goal == 0 && $urandom_range(0, 9) == 0) begin
         repeat ($urandom_range(1, 24))
            text.push_back(8'($urandom_range(0, 255)));
      end else begin
         commands = $urandom_range(1, 8);
         while (commands > 0 || points < point_goal) begin
            kind = $urandom_range(0, (point_goal > 0) ? 14 : 15);
            if (kind == 15) begin
               text.push_back(CHAR_CLOSE);
            end else if (kind == 14) begin
               text.push_back(random_separator());
            end else begin
               text.push_back((kind < 4) ? CHAR_MOVE : (kind < 9) ? CHAR_LINE : CHAR_CURVE);
               numbers = (kind < 9) ? int'(LINE_NUMBERS) : int'(CURVE_NUMBERS);
               points += numbers / 2;
               if ($urandom_range(0, 1) == 1)
                  text.push_back(random_separator());
               for (int n = 0; n < numbers; n++) begin
                  if ($urandom_range(0, 7) == 0)
                     repeat ($urandom_range(1, 3)) text.push_back(CHAR_ZERO);
                  digits = $sformatf("%0d", random_value(point_goal > 0));
                  foreach (digits[i])
                     text.push_back(digits[i]);
                  if (n < numbers - 1 || $urandom_range(0, 9) < 7)
                     text.push_back(random_separator());
               end
            end
            commands--;
         end
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
         if (point_goal == 0 && $urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, text.size());
            while (text.size() > cut)
               void'(text.pop_back());
         end
      end
      foreach (text[i])
         push_char(text[i]);
      end_path();
   endfunction

   task automatic send_char(input path_char_type item);
      req_bus.valid         <= 1'b1;
      req_bus.char_code     <= item.ch;
      req_bus.end_of_string <= item.eos;
      do
         @(posedge clock);
      while (!req_bus.ready);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0)
         @(negedge clock);
   endtask

   initial begin
      int directed_total;
      int midpoint;
      int burst_left;
      int gap;
      int path_number;

      req_bus.valid         = 1'b0;
      req_bus.char_code     = 8'h00;
      req_bus.end_of_string = 1'b0;
      rsp_bus.ready         = 1'b0;

      push_char(CHAR_LOW);
      push_char(CHAR_MOVE);
      push_text("70000 0");
      push_char(CHAR_LINE);
      push_text("1,2");
      end_path();
      push_char(CHAR_CURVE);
      push_text("9 8");
      push_char(CHAR_HIGH);
      end_path();
      push_char(CHAR_CLOSE);
      push_char(CHAR_MOVE);
      push_text("1 2 ");
      end_path();
      directed_total = stimulus.size();

      path_number = 0;
      while (stimulus.size() - directed_total < RANDOM_ITEMS) begin
         append_random_path((path_number == 0 || path_number == 40) ? LONG_POINTS : 0);
         path_number++;
      end
      midpoint = directed_total + (stimulus.size() - directed_total) / 2;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      burst_left = 0;
      foreach (stimulus[i]) begin
         if (i == directed_total || i == midpoint) begin
            drain_results();
            burst_left = 0;
         end
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_bus.valid <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         send_char(stimulus[i]);
         burst_left--;
      end

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
